@@ src/rgauge_pkg.sv @@
// Shared widths, constants and controller/datapath interface types for the rain gauge core.
package rgauge_pkg;

  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WIN_W     = 22;
  localparam int unsigned RATE_W    = 28;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned DT_W      = 12;
  localparam int unsigned DIV_STEPS = RATE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int unsigned STORE_DEPTH_DEF = 256;

  localparam logic [WIN_W-1:0]  WINDOW_RESET  = WIN_W'(86400);
  localparam logic [DT_W-1:0]   SECS_PER_HOUR = DT_W'(3600);
  localparam logic [RATE_W-1:0] RATE_MAX      = RATE_W'(235926000);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture the input beat
    logic first_upd;    // first update: remember the count only
    logic rd_newest;    // read the newest entry
    logic wr_replace;   // same timestamp: overwrite newest amount
    logic wr_append;    // append a new entry
    logic drop_oldest;  // store full: drop the oldest alongside the append
    logic prune_pop;    // expired oldest entry leaves the store
    logic sum_clr;      // start a window walk at the oldest entry
    logic sum_rd;       // read the next entry of the walk
    logic mul;          // form the division numerator
    logic div_init;
    logic div_step;
    logic rate_upd;     // commit rate, previous count and last rain time
  } rgauge_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic opcode;
    logic have_prev;
    logic inc_nz;
    logic count_zero;
    logic full;
    logic newest_match;
    logic prune_hit;
    logic walk_done;
    logic div_done;
  } rgauge_sts_t;

endpackage

@@ src/rgauge_ctrl.sv @@
// Sequencing state machine for the rain gauge core.
module rgauge_ctrl import rgauge_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  rgauge_sts_t sts_i,
  output logic        busy_o,
  output logic        strobe_o,
  output rgauge_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_NEWEST,
    S_PRUNE_RD,
    S_PRUNE_CHK,
    S_DIV_INIT,
    S_DIV,
    S_RATE,
    S_SUM,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   strobe_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:      cmd_o.load = start_i;
      S_DECODE: begin
        if (sts_i.opcode == OP_QUERY) begin
          cmd_o.sum_clr = 1'b1;
        end else if (!sts_i.have_prev) begin
          cmd_o.first_upd = 1'b1;
        end else if (sts_i.inc_nz) begin
          if (sts_i.count_zero) begin
            cmd_o.wr_append = 1'b1;
          end else begin
            cmd_o.rd_newest = 1'b1;
          end
        end
      end
      S_NEWEST: begin
        if (sts_i.newest_match) begin
          cmd_o.wr_replace = 1'b1;
        end else begin
          cmd_o.wr_append   = 1'b1;
          cmd_o.drop_oldest = sts_i.full;
        end
      end
      S_PRUNE_RD:  ;
      S_PRUNE_CHK: begin
        if (!sts_i.count_zero && sts_i.prune_hit) begin
          cmd_o.prune_pop = 1'b1;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      S_DIV_INIT:  cmd_o.div_init = 1'b1;
      S_DIV:       cmd_o.div_step = !sts_i.div_done;
      S_RATE:      cmd_o.rate_upd = 1'b1;
      S_SUM:       cmd_o.sum_rd   = !sts_i.walk_done;
      S_EMIT:      ;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      busy_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            busy_q  <= 1'b1;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (sts_i.opcode == OP_QUERY) begin
            state_q <= S_SUM;
          end else if (!sts_i.have_prev) begin
            state_q <= S_EMIT;
          end else if (sts_i.inc_nz && !sts_i.count_zero) begin
            state_q <= S_NEWEST;
          end else begin
            state_q <= S_PRUNE_RD;
          end
        end
        S_NEWEST:    state_q <= S_PRUNE_RD;
        S_PRUNE_RD:  state_q <= S_PRUNE_CHK;
        S_PRUNE_CHK: begin
          if (!sts_i.count_zero && sts_i.prune_hit) begin
            state_q <= S_PRUNE_RD;
          end else begin
            state_q <= S_DIV_INIT;
          end
        end
        S_DIV_INIT:  state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_RATE;
          end
        end
        S_RATE:      state_q <= S_EMIT;
        S_SUM: begin
          if (sts_i.walk_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe_q <= 1'b1;
          busy_q   <= 1'b0;
          state_q  <= S_IDLE;
        end
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = busy_q;
  assign strobe_o = strobe_q;

endmodule

@@ src/rgauge_dp.sv @@
// Datapath: entry store, prune and window-sum walk, rate divider and result registers.
module rgauge_dp import rgauge_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               opcode_i,
  input  logic [COUNT_W-1:0] counter_value_i,
  input  logic [TIME_W-1:0]  current_time_i,
  input  logic [TIME_W-1:0]  sum_duration_i,
  input  rgauge_cmd_t        cmd_i,
  output rgauge_sts_t        sts_o,
  output logic [RATE_W-1:0]  rain_rate_o,
  output logic [SUM_W-1:0]   window_sum_o,
  output logic               store_overflow_o
);

  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
    ptr_next = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [WIN_W-1:0] window_q;

  // captured beat
  logic               opcode_q;
  logic [COUNT_W-1:0] value_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  dur_q;

  // persistent state
  logic               have_prev_q;
  logic [COUNT_W-1:0] prev_q;
  logic [TIME_W-1:0]  last_q;
  logic [RATE_W-1:0]  rate_q;
  logic [IDX_W-1:0]   oldest_q;
  logic [IDX_W-1:0]   wr_ptr_q;
  logic [CNT_W-1:0]   count_q;

  // store
  logic [TIME_W-1:0]  time_mem [STORE_DEPTH];
  logic [COUNT_W-1:0] amt_mem  [STORE_DEPTH];
  logic [TIME_W-1:0]  rd_time_q;
  logic [COUNT_W-1:0] rd_amt_q;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   newest;

  // window walk
  logic [IDX_W-1:0]   walk_ptr_q;
  logic [CNT_W-1:0]   walk_cnt_q;
  logic               sum_vld_q;
  logic [SUM_W-1:0]   acc_q;
  logic               ovf_q;
  logic               in_win;
  logic [SUM_W:0]     acc_sum;

  // rate
  logic [COUNT_W-1:0] inc;
  logic [TIME_W-1:0]  dt;
  logic               dt_short;
  logic [RATE_W-1:0]  quo_q;
  logic [DT_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DT_W:0]      rem_sh;
  logic               rem_ge;
  logic [RATE_W-1:0]  quo_sat;

  assign inc      = (value_q >= prev_q) ? value_q - prev_q : value_q;
  assign dt       = now_q - last_q;
  assign dt_short = dt < TIME_W'(SECS_PER_HOUR);
  assign newest   = (wr_ptr_q == '0) ? LAST_IDX : wr_ptr_q - 1'b1;

  always_comb begin
    priority if (cmd_i.sum_rd) begin
      rd_addr = walk_ptr_q;
    end else if (cmd_i.rd_newest) begin
      rd_addr = newest;
    end else begin
      rd_addr = oldest_q;
    end
  end

  assign wr_addr = cmd_i.wr_replace ? newest : wr_ptr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_append) begin
      time_mem[wr_addr] <= now_q;
    end
    if (cmd_i.wr_append || cmd_i.wr_replace) begin
      amt_mem[wr_addr] <= inc;
    end
    rd_time_q <= time_mem[rd_addr];
    rd_amt_q  <= amt_mem[rd_addr];
  end

  assign in_win  = ({1'b0, rd_time_q} + {1'b0, dur_q}) > {1'b0, now_q};
  assign acc_sum = {1'b0, acc_q} + (SUM_W + 1)'(rd_amt_q);

  // restoring divider, one quotient bit a cycle; result unused if dt is an hour or more
  assign rem_sh  = {rem_q, quo_q[RATE_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dt[DT_W-1:0]};
  assign quo_sat = (dt[DT_W-1:0] == '0) ? RATE_MAX : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RESET;
      opcode_q    <= OP_UPDATE;
      value_q     <= '0;
      now_q       <= '0;
      dur_q       <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      last_q      <= '0;
      rate_q      <= '0;
      oldest_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      walk_ptr_q  <= '0;
      walk_cnt_q  <= '0;
      sum_vld_q   <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end

      if (cmd_i.load) begin
        opcode_q <= opcode_i;
        value_q  <= counter_value_i;
        now_q    <= current_time_i;
        dur_q    <= sum_duration_i;
        acc_q    <= '0;
        ovf_q    <= 1'b0;
      end

      if (cmd_i.first_upd) begin
        have_prev_q <= 1'b1;
        prev_q      <= value_q;
      end

      // store pointers
      if (cmd_i.prune_pop) begin
        oldest_q <= ptr_next(oldest_q);
        count_q  <= count_q - 1'b1;
      end else if (cmd_i.wr_append) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
        if (cmd_i.drop_oldest) begin
          oldest_q <= ptr_next(oldest_q);
          ovf_q    <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end

      // window walk, one entry a cycle; each entry is accumulated from the registered read data
      sum_vld_q <= cmd_i.sum_rd;
      if (cmd_i.sum_clr) begin
        walk_ptr_q <= oldest_q;
        walk_cnt_q <= '0;
      end else if (cmd_i.sum_rd) begin
        walk_ptr_q <= ptr_next(walk_ptr_q);
        walk_cnt_q <= walk_cnt_q + 1'b1;
      end
      if (sum_vld_q && in_win) begin
        acc_q <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
      end

      // rate numerator and division
      if (cmd_i.mul) begin
        quo_q <= (inc != '0) ? RATE_W'(inc) * RATE_W'(SECS_PER_HOUR)
                             : RATE_W'(SECS_PER_HOUR);
      end else if (cmd_i.div_step) begin
        quo_q     <= {quo_q[RATE_W-2:0], rem_ge};
        rem_q     <= rem_ge ? DT_W'(rem_sh - {1'b0, dt[DT_W-1:0]}) : rem_sh[DT_W-1:0];
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.div_init) begin
        rem_q     <= '0;
        div_cnt_q <= '0;
      end

      if (cmd_i.rate_upd) begin
        if (!dt_short) begin
          rate_q <= '0;
        end else if (inc != '0) begin
          rate_q <= quo_sat;
        end else if (quo_sat < rate_q) begin
          rate_q <= quo_sat;
        end
        prev_q <= value_q;
        if (inc != '0) begin
          last_q <= now_q;
        end
      end
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.opcode       = opcode_q;
    sts_o.have_prev    = have_prev_q;
    sts_o.inc_nz       = inc != '0;
    sts_o.count_zero   = count_q == '0;
    sts_o.full         = count_q == CNT_W'(STORE_DEPTH);
    sts_o.newest_match = rd_time_q == now_q;
    sts_o.prune_hit    = ({1'b0, rd_time_q} + (TIME_W + 1)'(window_q)) <= {1'b0, now_q};
    sts_o.walk_done    = walk_cnt_q == count_q;
    sts_o.div_done     = div_cnt_q == DIV_CNT_W'(DIV_STEPS);
  end

  assign rain_rate_o      = rate_q;
  assign window_sum_o     = acc_q;
  assign store_overflow_o = ovf_q;

endmodule

@@ src/rain_gauge_rate_and_window_sum_core.sv @@
// Top level of the rain gauge rate and window sum core.
//
//   channel   direction  ports                                           beat taken when
//   --------  ---------  ----------------------------------------------  -------------------
//   command   in         start, opcode_i, counter_value_i,               start && !busy
//                        current_time_i, sum_duration_i
//   result    out        result_valid_o, rain_rate_o, window_sum_o,      result_valid_o
//                        store_overflow_o
//   config    in         cfg_we_i, cfg_wdata_i (window_seconds)          cfg_we_i
//
// Sequencing: one beat at a time. A query walks the store from the oldest entry, with
// one pipelined store read per entry, before the strobe. An update runs the read/compare
// prune loop once per pruned entry and then the 28-step restoring divider; the first
// update after reset skips both and goes straight to the strobe.
// Reset: rst_ni clears pointers, counts and the rate at once; the store itself is
// not cleared, only the count entries from the oldest onward are ever used.
// Stalls: none on the result side; the strobe lasts one cycle and the next beat
// may be accepted in that same cycle.
module rain_gauge_rate_and_window_sum_core import rgauge_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [COUNT_W-1:0] counter_value_i,
  input  logic [TIME_W-1:0]  current_time_i,
  input  logic [TIME_W-1:0]  sum_duration_i,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic [RATE_W-1:0]  rain_rate_o,
  output logic [SUM_W-1:0]   window_sum_o,
  output logic               store_overflow_o
);

  rgauge_cmd_t cmd;
  rgauge_sts_t sts;
  logic        busy_w;

  // controller: decides order of store, prune, divide and walk steps
  rgauge_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .busy_o   (busy_w),
    .strobe_o (result_valid_o),
    .cmd_o    (cmd)
  );

  // datapath: circular entry store, accumulator, divider, output registers
  rgauge_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .counter_value_i  (counter_value_i),
    .current_time_i   (current_time_i),
    .sum_duration_i   (sum_duration_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rain_rate_o      (rain_rate_o),
    .window_sum_o     (window_sum_o),
    .store_overflow_o (store_overflow_o)
  );

  assign busy = busy_w;

  // strobe is a single-cycle pulse
  a_strobe_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // the result is shown only once the block has gone idle
  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // an overflow only comes from an update, which never carries a window sum
  a_ovf_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && store_overflow_o) |-> (window_sum_o == '0))
    else $error("overflow flagged on a query result");

  // an accepted beat makes the block busy in the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule
